// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// clocked check, live through reset
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// File: rtl/core/dpdd_pkg.sv
package dpdd_pkg;

    localparam int DataW    = 24;
    localparam int ErrW     = DataW + 1;
    localparam int D1W      = ErrW + 1;
    localparam int D2W      = ErrW + 2;
    localparam int GainW    = 16;
    localparam int ProdW    = GainW + D2W;
    localparam int SumW     = ProdW + 2;
    localparam int FracW    = 8;
    localparam int QW       = SumW - FracW;
    localparam int DriveW   = DataW + 1;
    localparam int DutyW    = 10;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam int MinDriveDef = 100;

    localparam logic [GainW-1:0] DistKpRst   = GainW'(2048);
    localparam logic [GainW-1:0] DistKiRst   = GainW'(0);
    localparam logic [GainW-1:0] DistKdRst   = GainW'(4608);
    localparam logic [GainW-1:0] OrientKpRst = GainW'(1280);
    localparam logic [GainW-1:0] OrientKiRst = GainW'(0);
    localparam logic [GainW-1:0] OrientKdRst = GainW'(6400);
    localparam logic [DutyW-1:0] LimitRst    = DutyW'(500);
    localparam logic [DutyW-1:0] DeadRst     = DutyW'(100);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DIST_KP,
        CFG_DIST_KI,
        CFG_DIST_KD,
        CFG_ORIENT_KP,
        CFG_ORIENT_KI,
        CFG_ORIENT_KD,
        CFG_DRIVE_LIMIT,
        CFG_DEAD_BAND
    } t_cfg_idx;

    typedef struct packed {
        logic [GainW-1:0] kp;
        logic [GainW-1:0] ki;
        logic [GainW-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic acc_en;
    } t_loop_ctrl;

endpackage

// File: rtl/core/dpdd_loop.sv
module dpdd_loop (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dpdd_pkg::t_loop_ctrl                i_ctrl,
    input  dpdd_pkg::t_gains                    i_gains,
    input  logic signed [dpdd_pkg::DataW-1:0]   i_target,
    input  logic signed [dpdd_pkg::DataW-1:0]   i_measured,
    output logic signed [dpdd_pkg::DataW-1:0]   o_accum
);
    import dpdd_pkg::*;

    logic signed [ErrW-1:0]  n_err;
    logic signed [ErrW-1:0]  r_hist0;
    logic signed [ErrW-1:0]  r_hist1;
    logic signed [ErrW-1:0]  r_e0;
    logic signed [D1W-1:0]   n_d1;
    logic signed [D1W-1:0]   r_d1;
    logic signed [D2W-1:0]   n_d2;
    logic signed [D2W-1:0]   r_d2;
    logic signed [ProdW-1:0] n_pp;
    logic signed [ProdW-1:0] n_pi;
    logic signed [ProdW-1:0] n_pd;
    logic signed [ProdW-1:0] r_pp;
    logic signed [ProdW-1:0] r_pi;
    logic signed [ProdW-1:0] r_pd;
    logic signed [SumW-1:0]  n_sum;
    logic                    n_rnd;
    logic signed [QW-1:0]    n_q;
    logic signed [DataW-1:0] n_accum;
    logic signed [DataW-1:0] r_accum;

    // error and its first and second differences
    always_comb begin
        n_err = ErrW'(i_target) - ErrW'(i_measured);
        n_d1  = D1W'(n_err) - D1W'(r_hist0);
        n_d2  = D2W'(n_err) - (D2W'(r_hist0) <<< 1) + D2W'(r_hist1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist0 <= '0;
            r_hist1 <= '0;
        end else if (i_ctrl.load) begin
            r_hist0 <= n_err;
            r_hist1 <= r_hist0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_e0 <= n_err;
            r_d1 <= n_d1;
            r_d2 <= n_d2;
        end
    end

    always_comb begin
        n_pp = ProdW'($signed({1'b0, i_gains.kp})) * ProdW'(r_d1);
        n_pi = ProdW'($signed({1'b0, i_gains.ki})) * ProdW'(r_e0);
        n_pd = ProdW'($signed({1'b0, i_gains.kd})) * ProdW'(r_d2);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_pp <= n_pp;
            r_pi <= n_pi;
            r_pd <= n_pd;
        end
    end

    // Q37.8 sum, truncate toward zero, saturate
    always_comb begin
        n_sum = SumW'($signed({r_accum, {FracW{1'b0}}}))
              + SumW'(r_pp) + SumW'(r_pi) + SumW'(r_pd);
        n_rnd = n_sum[SumW-1] & (|n_sum[FracW-1:0]);
        n_q   = $signed(n_sum[SumW-1:FracW]) + $signed({{(QW-1){1'b0}}, n_rnd});
        if (n_q[QW-1:DataW-1] == '0 || n_q[QW-1:DataW-1] == '1) begin
            n_accum = n_q[DataW-1:0];
        end else if (n_q[QW-1]) begin
            n_accum = {1'b1, {(DataW-1){1'b0}}};
        end else begin
            n_accum = {1'b0, {(DataW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (i_ctrl.acc_en) begin
            r_accum <= n_accum;
        end
    end

    assign o_accum = r_accum;

endmodule

// File: rtl/core/dpdd_shape.sv
module dpdd_shape #(
    parameter int MIN_DRIVE = dpdd_pkg::MinDriveDef
) (
    input  logic signed [dpdd_pkg::DataW-1:0] i_dist,
    input  logic signed [dpdd_pkg::DataW-1:0] i_orient,
    input  logic                              i_sub,
    input  logic [dpdd_pkg::DutyW-1:0]        i_limit,
    input  logic [dpdd_pkg::DutyW-1:0]        i_dead,
    output logic [dpdd_pkg::DutyW-1:0]        o_duty,
    output logic                              o_forward
);
    import dpdd_pkg::*;

    localparam logic [DutyW-1:0] MinMag = DutyW'(MIN_DRIVE);

    logic signed [DriveW-1:0] n_drive;
    logic [DriveW-1:0]        n_mag;

    always_comb begin
        if (i_sub) begin
            n_drive = DriveW'(i_dist) - DriveW'(i_orient);
        end else begin
            n_drive = DriveW'(i_dist) + DriveW'(i_orient);
        end
        n_mag = n_drive[DriveW-1] ? DriveW'(-n_drive) : DriveW'(n_drive);

        priority if (n_mag > DriveW'(i_limit)) begin
            o_duty = i_limit;
        end else if (n_mag < DriveW'(i_dead)) begin
            o_duty = '0;
        end else if (n_mag < DriveW'(MinMag)) begin
            o_duty = MinMag;
        end else begin
            o_duty = n_mag[DutyW-1:0];
        end
        o_forward = !n_drive[DriveW-1] && (o_duty != '0);
    end

endmodule

// File: rtl/core/dual_pid_differential_drive_top.sv
// Dual velocity-form PID for a differential drive. One sample word is taken per clock while the
// output side does not stall, and its drive word passes these registered stages: stage one forms
// the errors and their differences, stage two the three gain products of each loop, stage three
// the truncated and saturated accumulators, stage four the clamped, dead-banded and lifted left
// and right duties. The accumulator adder of each loop closes on itself, which sets the sustained
// rate of one sample per clock while the output side does not stall. Write the gain and limit
// registers only while no sample is in flight.
module dual_pid_differential_drive_top #(
    parameter int MIN_DRIVE = dpdd_pkg::MinDriveDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [dpdd_pkg::DataW-1:0]    i_target_distance,
    input  logic signed [dpdd_pkg::DataW-1:0]    i_target_angle,
    input  logic signed [dpdd_pkg::DataW-1:0]    i_measured_distance,
    input  logic signed [dpdd_pkg::DataW-1:0]    i_measured_angle,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [dpdd_pkg::DutyW-1:0]           o_right_duty,
    output logic                                 o_right_forward,
    output logic [dpdd_pkg::DutyW-1:0]           o_left_duty,
    output logic                                 o_left_forward,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dpdd_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [dpdd_pkg::CfgDataW-1:0]        i_cfg_data
);
    import dpdd_pkg::*;

    t_gains            r_dist_gains;
    t_gains            r_orient_gains;
    logic [DutyW-1:0]  r_limit;
    logic [DutyW-1:0]  r_dead;

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_v4;
    logic              adv1;
    logic              adv2;
    logic              adv3;
    logic              adv4;
    t_loop_ctrl        loop_ctrl;

    logic signed [DataW-1:0] dist_accum;
    logic signed [DataW-1:0] orient_accum;
    logic [DutyW-1:0]        n_right_duty;
    logic [DutyW-1:0]        n_left_duty;
    logic                    n_right_fwd;
    logic                    n_left_fwd;
    logic [DutyW-1:0]        r_right_duty;
    logic [DutyW-1:0]        r_left_duty;
    logic                    r_right_fwd;
    logic                    r_left_fwd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_gains   <= '{kp: DistKpRst, ki: DistKiRst, kd: DistKdRst};
            r_orient_gains <= '{kp: OrientKpRst, ki: OrientKiRst, kd: OrientKdRst};
            r_limit        <= LimitRst;
            r_dead         <= DeadRst;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIST_KP:     r_dist_gains.kp   <= i_cfg_data;
                CFG_DIST_KI:     r_dist_gains.ki   <= i_cfg_data;
                CFG_DIST_KD:     r_dist_gains.kd   <= i_cfg_data;
                CFG_ORIENT_KP:   r_orient_gains.kp <= i_cfg_data;
                CFG_ORIENT_KI:   r_orient_gains.ki <= i_cfg_data;
                CFG_ORIENT_KD:   r_orient_gains.kd <= i_cfg_data;
                CFG_DRIVE_LIMIT: r_limit           <= i_cfg_data[DutyW-1:0];
                CFG_DEAD_BAND:   r_dead            <= i_cfg_data[DutyW-1:0];
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        adv4 = !r_v4 || i_out_ready;
        adv3 = !r_v3 || adv4;
        adv2 = !r_v2 || adv3;
        adv1 = !r_v1 || adv2;
        loop_ctrl.load   = i_in_valid && adv1;
        loop_ctrl.mul_en = adv2 && r_v1;
        loop_ctrl.acc_en = adv3 && r_v2;
    end

    assign o_in_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    dpdd_loop u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (loop_ctrl),
        .i_gains    (r_dist_gains),
        .i_target   (i_target_distance),
        .i_measured (i_measured_distance),
        .o_accum    (dist_accum)
    );

    dpdd_loop u_orient (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (loop_ctrl),
        .i_gains    (r_orient_gains),
        .i_target   (i_target_angle),
        .i_measured (i_measured_angle),
        .o_accum    (orient_accum)
    );

    dpdd_shape #(.MIN_DRIVE(MIN_DRIVE)) u_right (
        .i_dist    (dist_accum),
        .i_orient  (orient_accum),
        .i_sub     (1'b0),
        .i_limit   (r_limit),
        .i_dead    (r_dead),
        .o_duty    (n_right_duty),
        .o_forward (n_right_fwd)
    );

    dpdd_shape #(.MIN_DRIVE(MIN_DRIVE)) u_left (
        .i_dist    (dist_accum),
        .i_orient  (orient_accum),
        .i_sub     (1'b1),
        .i_limit   (r_limit),
        .i_dead    (r_dead),
        .o_duty    (n_left_duty),
        .o_forward (n_left_fwd)
    );

    always_ff @(posedge i_clk) begin
        if (adv4 && r_v3) begin
            r_right_duty <= n_right_duty;
            r_right_fwd  <= n_right_fwd;
            r_left_duty  <= n_left_duty;
            r_left_fwd   <= n_left_fwd;
        end
    end

    assign o_out_valid     = r_v4;
    assign o_right_duty    = r_right_duty;
    assign o_right_forward = r_right_fwd;
    assign o_left_duty     = r_left_duty;
    assign o_left_forward  = r_left_fwd;

endmodule

// File: rtl/core/dpdd_checker.sv
`include "assert_macros.svh"

module dpdd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [dpdd_pkg::DutyW-1:0]  o_right_duty,
    input logic                        o_right_forward,
    input logic [dpdd_pkg::DutyW-1:0]  o_left_duty,
    input logic                        o_left_forward
);

    logic [2*dpdd_pkg::DutyW+1:0] out_word;
    logic                         zero_fwd;

    assign out_word = {o_right_duty, o_right_forward, o_left_duty, o_left_forward};
    assign zero_fwd = (o_right_forward && o_right_duty == '0)
                   || (o_left_forward && o_left_duty == '0);

    `ASSERT_CLK(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    `ASSERT_CLKD(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(out_word))

    `ASSERT_CLKD(a_stall_only_on_back, i_clk, i_rst_n, !o_in_ready |-> o_out_valid && !i_out_ready)

    `ASSERT_CLKD(a_zero_is_reverse, i_clk, i_rst_n, o_out_valid |-> !zero_fwd)

endmodule

bind dual_pid_differential_drive_top dpdd_checker u_dpdd_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dpdd_pkg::*;

    localparam longint AccMax       = 64'sd8388607;
    localparam longint AccMin       = -64'sd8388608;
    localparam longint MinDrive     = longint'(MinDriveDef);
    localparam logic signed [DataW-1:0] DataMax = 24'sh7fffff;
    localparam logic signed [DataW-1:0] DataMin = 24'sh800000;
    localparam logic [GainW-1:0]  GainMax      = 16'hffff;
    localparam logic [GainW-1:0]  UnitGain     = 16'd256;
    localparam int                HoldCycles   = 300;
    localparam int                SettleCycles = 8;

    typedef struct {
        logic [DutyW-1:0] right_duty;
        logic             right_forward;
        logic [DutyW-1:0] left_duty;
        logic             left_forward;
    } t_drive_word;

    class t_drive_checker;
        logic [GainW-1:0] dist_kp, dist_ki, dist_kd;
        logic [GainW-1:0] orient_kp, orient_ki, orient_kd;
        logic [DutyW-1:0] drive_limit, dead_band;
        longint           dist_hist[2], orient_hist[2];
        longint           dist_acc, orient_acc;
        t_drive_word      expected_drives[$];
        int               mismatches;

        function new();
            dist_kp     = DistKpRst;
            dist_ki     = DistKiRst;
            dist_kd     = DistKdRst;
            orient_kp   = OrientKpRst;
            orient_ki   = OrientKiRst;
            orient_kd   = OrientKdRst;
            drive_limit = LimitRst;
            dead_band   = DeadRst;
            dist_hist   = '{0, 0};
            orient_hist = '{0, 0};
            dist_acc    = 0;
            orient_acc  = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_DIST_KP:     dist_kp = data;
                CFG_DIST_KI:     dist_ki = data;
                CFG_DIST_KD:     dist_kd = data;
                CFG_ORIENT_KP:   orient_kp = data;
                CFG_ORIENT_KI:   orient_ki = data;
                CFG_ORIENT_KD:   orient_kd = data;
                CFG_DRIVE_LIMIT: drive_limit = data[DutyW-1:0];
                CFG_DEAD_BAND:   dead_band = data[DutyW-1:0];
                default: ;
            endcase
        endfunction

        function longint next_accum(longint e0, longint e1, longint e2, longint acc,
                                    logic [GainW-1:0] kp, logic [GainW-1:0] ki,
                                    logic [GainW-1:0] kd);
            longint total, q;
            total = acc * 256 + longint'(kp) * (e0 - e1) + longint'(ki) * e0
                  + longint'(kd) * (e0 - 2 * e1 + e2);
            q = total / 256;
            if (q > AccMax) q = AccMax;
            if (q < AccMin) q = AccMin;
            return q;
        endfunction

        function longint shape_drive(longint v);
            longint lim, dead, mag;
            lim  = longint'(drive_limit);
            dead = longint'(dead_band);
            mag  = (v < 0) ? -v : v;
            if (v < -lim) return -lim;
            if (v > lim) return lim;
            if (mag < dead) return 0;
            if (mag < MinDrive) return (v < 0) ? -MinDrive : MinDrive;
            return v;
        endfunction

        function void note_sample(input logic signed [DataW-1:0] td, ta, md, ma);
            longint      de, oe, left, right;
            t_drive_word w;
            oe = longint'(ta) - longint'(ma);
            de = longint'(td) - longint'(md);
            orient_acc = next_accum(oe, orient_hist[0], orient_hist[1], orient_acc,
                                    orient_kp, orient_ki, orient_kd);
            orient_hist[1] = orient_hist[0];
            orient_hist[0] = oe;
            dist_acc = next_accum(de, dist_hist[0], dist_hist[1], dist_acc,
                                  dist_kp, dist_ki, dist_kd);
            dist_hist[1] = dist_hist[0];
            dist_hist[0] = de;
            left  = shape_drive(dist_acc - orient_acc);
            right = shape_drive(dist_acc + orient_acc);
            w.right_duty    = DutyW'((right < 0) ? -right : right);
            w.right_forward = (right > 0);
            w.left_duty     = DutyW'((left < 0) ? -left : left);
            w.left_forward  = (left > 0);
            expected_drives.push_back(w);
        endfunction

        function void check_drive(logic [DutyW-1:0] rd, logic rf,
                                  logic [DutyW-1:0] ld, logic lf);
            t_drive_word w;
            if (expected_drives.size() == 0) begin
                $error("drive word with none expected");
                mismatches++;
                return;
            end
            w = expected_drives.pop_front();
            if (rd !== w.right_duty) begin
                $error("right_duty: expected %0d, got %0d", w.right_duty, rd);
                mismatches++;
            end
            if (rf !== w.right_forward) begin
                $error("right_forward: expected %0b, got %0b", w.right_forward, rf);
                mismatches++;
            end
            if (ld !== w.left_duty) begin
                $error("left_duty: expected %0d, got %0d", w.left_duty, ld);
                mismatches++;
            end
            if (lf !== w.left_forward) begin
                $error("left_forward: expected %0b, got %0b", w.left_forward, lf);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [DataW-1:0] i_target_distance;
    logic signed [DataW-1:0] i_target_angle;
    logic signed [DataW-1:0] i_measured_distance;
    logic signed [DataW-1:0] i_measured_angle;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [DutyW-1:0]        o_right_duty;
    logic                    o_right_forward;
    logic [DutyW-1:0]        o_left_duty;
    logic                    o_left_forward;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CfgIdxW-1:0]      i_cfg_index;
    logic [CfgDataW-1:0]     i_cfg_data;

    bit                      tx_steady;
    bit                      rx_steady;
    bit                      hold_req;
    logic signed [DataW-1:0] dist_pos;
    logic signed [DataW-1:0] angle_pos;

    t_drive_checker sb = new();

    dual_pid_differential_drive_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_target_distance   (i_target_distance),
        .i_target_angle      (i_target_angle),
        .i_measured_distance (i_measured_distance),
        .i_measured_angle    (i_measured_angle),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_right_duty        (o_right_duty),
        .o_right_forward     (o_right_forward),
        .o_left_duty         (o_left_duty),
        .o_left_forward      (o_left_forward),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("** dual_pid_differential_drive_top: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_sample(i_target_distance, i_target_angle, i_measured_distance,
                           i_measured_angle);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_drive(o_right_duty, o_right_forward, o_left_duty, o_left_forward);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            sb.set_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
        end
    end

    function automatic int idle_span();
        return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, or one long hold-off on request
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_steady || $urandom_range(0, 99) < 65) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b0;
                repeat (idle_span() - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic signed [DataW-1:0] td, ta, md, ma);
        int gap;
        @(negedge i_clk);
        i_in_valid          = 1'b1;
        i_target_distance   = td;
        i_target_angle      = ta;
        i_measured_distance = md;
        i_measured_angle    = ma;
        do @(posedge i_clk); while (!o_in_ready);
        if (!tx_steady && $urandom_range(0, 99) < 30) begin
            gap = idle_span();
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic program_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic load_gains(input logic [GainW-1:0] dkp, dki, dkd, okp, oki, okd);
        program_reg(CFG_DIST_KP, dkp);
        program_reg(CFG_DIST_KI, dki);
        program_reg(CFG_DIST_KD, dkd);
        program_reg(CFG_ORIENT_KP, okp);
        program_reg(CFG_ORIENT_KI, oki);
        program_reg(CFG_ORIENT_KD, okd);
    endtask

    task automatic load_setting(input logic [GainW-1:0] dkp, dki, dkd, okp, oki, okd,
                                input logic [DutyW-1:0] lim, dead);
        settle();
        load_gains(dkp, dki, dkd, okp, oki, okd);
        program_reg(CFG_DRIVE_LIMIT, CfgDataW'(lim));
        program_reg(CFG_DEAD_BAND, CfgDataW'(dead));
    endtask

    // pure unit integral gain: one word cancels each accumulator, two zero words
    // flush the error history
    task automatic recentre();
        logic signed [DataW-1:0] dacc, oacc;
        settle();
        load_gains('0, UnitGain, '0, '0, UnitGain, '0);
        dacc = DataW'(sb.dist_acc);
        oacc = DataW'(sb.orient_acc);
        send_sample('0, '0, dacc, oacc);
        send_sample('0, '0, '0, '0);
        send_sample('0, '0, '0, '0);
    endtask

    task automatic run_random(input int n, input bit with_hold, input int noise_pct);
        int                      kind, span;
        logic signed [DataW-1:0] td, ta, md, ma;
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == n / 3) begin
                hold_req  = 1'b1;
                tx_steady = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < noise_pct) begin
                td = DataW'($urandom);
                ta = DataW'($urandom);
                md = DataW'($urandom);
                ma = DataW'($urandom);
            end else begin
                if ($urandom_range(0, 99) < 5) begin
                    dist_pos  = DataW'($urandom);
                    angle_pos = DataW'($urandom);
                end
                dist_pos  = dist_pos + DataW'(int'($urandom_range(0, 64)) - 32);
                angle_pos = angle_pos + DataW'(int'($urandom_range(0, 64)) - 32);
                span = 1 << $urandom_range(0, 10);
                td = dist_pos;
                md = dist_pos - DataW'(int'($urandom_range(0, 2 * span)) - span);
                ta = angle_pos;
                ma = angle_pos - DataW'(int'($urandom_range(0, 2 * span)) - span);
            end
            send_sample(td, ta, md, ma);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_target_distance   = '0;
        i_target_angle      = '0;
        i_measured_distance = '0;
        i_measured_angle    = '0;
        i_out_ready         = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        tx_steady           = 1'b0;
        rx_steady           = 1'b0;
        hold_req            = 1'b0;
        dist_pos            = '0;
        angle_pos           = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // small errors at reset gains: dead band, lift and direction
        send_sample(0, 0, 0, 0);
        send_sample(5, 0, 0, 0);
        send_sample(12, 3, 0, 0);
        send_sample(12, -4, 0, 0);
        send_sample(0, 0, 3, 0);
        send_sample(-20, 0, 0, 7);
        send_sample(0, 0, 0, 0);
        send_sample(1, 0, 0, 0);
        send_sample(0, 0, 1, 0);
        send_sample(0, 2, 0, 0);
        // field extremes, accumulator saturation both ways
        send_sample(DataMax, 0, DataMin, 0);
        send_sample(0, DataMax, 0, DataMin);
        send_sample(DataMin, DataMin, DataMax, DataMax);
        send_sample(DataMax, DataMax, DataMax, DataMax);
        send_sample(DataMin, 0, DataMax, 0);
        send_sample(0, DataMin, 0, DataMax);
        send_sample(DataMin, DataMin, DataMin, DataMin);

        recentre();
        load_setting(GainMax, GainMax, GainMax, GainMax, GainMax, GainMax, 10'd1023, 10'd0);
        run_random(40, 1'b0, 50);

        recentre();
        load_setting('0, '0, '0, '0, '0, '0, 10'd0, 10'd0);
        run_random(30, 1'b0, 50);

        recentre();
        load_setting(DistKpRst, DistKiRst, DistKdRst, OrientKpRst, OrientKiRst, OrientKdRst,
                     LimitRst, DeadRst);
        run_random(300, 1'b1, 0);

        // limit under dead band and under the minimum drive
        recentre();
        load_setting(GainW'($urandom_range(0, 1024)), GainW'($urandom_range(0, 32)),
                     GainW'($urandom_range(0, 2048)), GainW'($urandom_range(0, 1024)),
                     GainW'($urandom_range(0, 32)), GainW'($urandom_range(0, 2048)),
                     10'd50, 10'd200);
        run_random(150, 1'b0, 0);

        // lift above the limit
        recentre();
        load_setting(GainW'($urandom_range(0, 1024)), GainW'($urandom_range(0, 32)),
                     GainW'($urandom_range(0, 2048)), GainW'($urandom_range(0, 1024)),
                     GainW'($urandom_range(0, 32)), GainW'($urandom_range(0, 2048)),
                     10'd60, 10'd20);
        run_random(150, 1'b0, 0);

        recentre();
        load_setting(GainW'($urandom_range(0, 2048)), GainW'($urandom_range(0, 32)),
                     GainW'($urandom_range(0, 4096)), GainW'($urandom_range(0, 2048)),
                     GainW'($urandom_range(0, 32)), GainW'($urandom_range(0, 4096)),
                     10'd1023, 10'd1023);
        run_random(100, 1'b0, 0);

        for (int k = 0; k < 4; k++) begin
            recentre();
            load_setting(($urandom_range(0, 3) == 0) ? GainW'($urandom)
                                                     : GainW'($urandom_range(0, 2048)),
                         GainW'($urandom_range(0, 48)),
                         GainW'($urandom_range(0, 4096)),
                         ($urandom_range(0, 3) == 0) ? GainW'($urandom)
                                                     : GainW'($urandom_range(0, 2048)),
                         GainW'($urandom_range(0, 48)),
                         GainW'($urandom_range(0, 4096)),
                         DutyW'($urandom_range(0, 1023)), DutyW'($urandom_range(0, 300)));
            run_random(130, 1'b0, 3);
        end

        settle();
        if (sb.mismatches == 0) begin
            $display("** dual_pid_differential_drive_top: PASSED **");
        end else begin
            $display("** dual_pid_differential_drive_top: FAILED **");
        end
        $finish;
    end

endmodule
